// ----- src/dpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpfr_pkg: shared types and constants of the demand page fault resolver
// Sizes of the segment table and the mapped-page rows, field widths, action
// and function codes, and the structs that travel between modules.
// ----------------------------------------------------------------------------
package dpfr_pkg;

  // Table geometry
  localparam int unsigned MAX_SEGMENTS          = 8;
  localparam int unsigned MAX_PAGES_PER_SEGMENT = 256;
  localparam int unsigned SLOT_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned PAGE_W =
      (MAX_PAGES_PER_SEGMENT > 1) ? $clog2(MAX_PAGES_PER_SEGMENT) : 1;

  // Field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 25;
  localparam int unsigned PERM_W     = 3;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned SEG_SLOT_W = 3;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned SCNT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // Page shift limits and reset value
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT  = 1'd1;

  // Input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FAULT = 1'b1;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_LOADED  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FILE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ZERO    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] mem_bytes;
    logic [SIZE_W-1:0] file_bytes;
    logic [ADDR_W-1:0] file_offset;
    logic [PERM_W-1:0] perm;
  } seg_desc_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] page_addr;
    logic [LEN_W-1:0]  map_len;
    logic [ADDR_W-1:0] map_file_offset;
    logic [PERM_W-1:0] map_perm;
  } result_t;

  // Outcome of resolving one matched fault
  typedef struct packed {
    result_t           res;
    logic              mark;      // set the page's mapped bit
    logic [PAGE_W-1:0] page_idx;
  } calc_t;

endpackage

// ----- src/dpfr_if.sv -----
// ----------------------------------------------------------------------------
// dpfr_if: valid/ready channels of the demand page fault resolver
// One interface for input transactions, one for result transactions.
// ----------------------------------------------------------------------------
interface dpfr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [dpfr_pkg::SEG_SLOT_W-1:0]     seg_slot;
  logic [dpfr_pkg::ADDR_W-1:0]         seg_base;
  logic [dpfr_pkg::SIZE_W-1:0]         seg_mem_size;
  logic [dpfr_pkg::SIZE_W-1:0]         seg_file_size;
  logic [dpfr_pkg::ADDR_W-1:0]         seg_file_offset;
  logic [dpfr_pkg::PERM_W-1:0]         seg_perm;
  logic [dpfr_pkg::ADDR_W-1:0]         fault_addr;

  modport source (
    output valid, func, seg_slot, seg_base, seg_mem_size, seg_file_size,
           seg_file_offset, seg_perm, fault_addr,
    input  ready
  );
  modport sink (
    input  valid, func, seg_slot, seg_base, seg_mem_size, seg_file_size,
           seg_file_offset, seg_perm, fault_addr,
    output ready
  );
endinterface

interface dpfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [dpfr_pkg::ACT_W-1:0]  action;
  logic [dpfr_pkg::ADDR_W-1:0] page_addr;
  logic [dpfr_pkg::LEN_W-1:0]  map_len;
  logic [dpfr_pkg::ADDR_W-1:0] map_file_offset;
  logic [dpfr_pkg::PERM_W-1:0] map_perm;

  modport source (
    output valid, action, page_addr, map_len, map_file_offset, map_perm,
    input  ready
  );
  modport sink (
    input  valid, action, page_addr, map_len, map_file_offset, map_perm,
    output ready
  );
endinterface

// ----- src/dpfr_ram.sv -----
// ----------------------------------------------------------------------------
// dpfr_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dpfr_page_calc.sv -----
// ----------------------------------------------------------------------------
// dpfr_page_calc: page resolution for a matched segment
// From the offset into the segment, find the page, test its mapped bit and
// build the file-backed, zero-fill or forward result.
// ----------------------------------------------------------------------------
module dpfr_page_calc (
  input  dpfr_pkg::seg_desc_t                              desc_i,
  input  logic [dpfr_pkg::SIZE_W-1:0]                      offset_i,
  input  logic [dpfr_pkg::MAX_PAGES_PER_SEGMENT-1:0]       row_i,
  input  logic [dpfr_pkg::SHIFT_W-1:0]                     shift_i,
  output dpfr_pkg::calc_t                                  calc_o
);

  logic [dpfr_pkg::LEN_W-1:0]  page;
  logic [dpfr_pkg::SIZE_W-1:0] page_ext;
  logic [dpfr_pkg::SIZE_W-1:0] done;
  logic [dpfr_pkg::SIZE_W-1:0] index;
  logic [dpfr_pkg::SIZE_W-1:0] remain;
  logic [dpfr_pkg::PAGE_W-1:0] page_idx;
  logic                        in_range;
  logic                        hit;
  logic                        file_left;

  always_comb begin
    page      = dpfr_pkg::LEN_W'(1) << shift_i;
    page_ext  = dpfr_pkg::SIZE_W'(page);
    done      = offset_i & ~(page_ext - dpfr_pkg::SIZE_W'(1));
    index     = offset_i >> shift_i;
    in_range  = index < dpfr_pkg::SIZE_W'(dpfr_pkg::MAX_PAGES_PER_SEGMENT);
    page_idx  = index[dpfr_pkg::PAGE_W-1:0];
    hit       = row_i[page_idx];
    file_left = desc_i.file_bytes > done;
    remain    = desc_i.file_bytes - done;

    calc_o          = '0;
    calc_o.page_idx = page_idx;
    if (!in_range || hit) begin
      calc_o.res.action = dpfr_pkg::ACT_FORWARD;
    end else begin
      calc_o.mark             = 1'b1;
      calc_o.res.page_addr    = desc_i.base + dpfr_pkg::ADDR_W'(done);
      calc_o.res.map_perm     = desc_i.perm;
      if (file_left) begin
        calc_o.res.action          = dpfr_pkg::ACT_FILE;
        // clip to the file bytes that remain
        calc_o.res.map_len         = (remain > page_ext) ? page
                                                         : dpfr_pkg::LEN_W'(remain);
        calc_o.res.map_file_offset = desc_i.file_offset + dpfr_pkg::ADDR_W'(done);
      end else begin
        calc_o.res.action  = dpfr_pkg::ACT_ZERO;
        calc_o.res.map_len = page;
      end
    end
  end

endmodule

// ----- src/demand_page_fault_resolver.sv -----
// ----------------------------------------------------------------------------
// demand_page_fault_resolver: segment table lookup and page fault resolution
// Holds segment descriptors and per-page mapped bits; answers each load or
// fault transaction with one result transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load transactions (func = 0, writes one segment descriptor
//   and clears that segment's mapped pages) and fault transactions (func = 1,
//   resolve fault_addr). out_ch returns exactly one result per transaction:
//   loaded, map file page, zero-fill page or forward fault.
//   cfg_we_i/cfg_idx_i/cfg_data_i write page_shift (index 0) and
//   segment_count (index 1); write them only while the block is idle.
// Sequencing:
//   One transaction is worked on at a time; the next is accepted only once
//   the sequencer is back in idle. A load goes straight to the emit state. A
//   fault reads one descriptor per cycle from the table memory in the scan
//   state: a first match goes on to the resolve state and then to emit; no
//   match, or no active segment, sends a forward result to emit.
// Reset:
//   page_shift returns to 12, segment_count to 0, all mapped rows read as
//   unmapped (one valid flop per row); descriptors are undefined until loaded.
// Stalls:
//   The result sits in an output register; the next transaction is accepted
//   while it waits. A new result waits in its own state until out_ch frees.
// ----------------------------------------------------------------------------
module demand_page_fault_resolver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dpfr_in_if.sink                           in_ch,
  dpfr_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [dpfr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpfr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_RESOLVE = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_e;

  localparam int unsigned DESC_W = $bits(dpfr_pkg::seg_desc_t);
  localparam int unsigned ROW_W  = dpfr_pkg::MAX_PAGES_PER_SEGMENT;

  state_e                              state_q, state_d;
  logic [dpfr_pkg::SHIFT_W-1:0]        page_shift_q;
  logic [dpfr_pkg::SCNT_W-1:0]         seg_count_q;
  logic [dpfr_pkg::SHIFT_W-1:0]        shift_eff;
  logic [dpfr_pkg::CNT_W-1:0]          cnt_eff;
  logic [dpfr_pkg::SLOT_W-1:0]         chk_slot_q, chk_slot_d;
  logic [dpfr_pkg::SLOT_W-1:0]         slot_q, slot_d;
  logic [dpfr_pkg::ADDR_W-1:0]         fault_addr_q, fault_addr_d;
  dpfr_pkg::seg_desc_t                 desc_q, desc_d;
  logic [dpfr_pkg::SIZE_W-1:0]         offset_q, offset_d;
  logic [ROW_W-1:0]                    row_q, row_d;
  dpfr_pkg::result_t                   res_q, res_d;
  dpfr_pkg::result_t                   out_q;
  logic                                out_valid_q;
  logic [dpfr_pkg::MAX_SEGMENTS-1:0]   row_vld_q;

  logic                                in_accept;
  logic                                load_acc;
  logic                                fault_acc;
  logic                                slot_ok;
  logic                                out_free;
  logic                                out_load;

  logic                                seg_we;
  logic [dpfr_pkg::SLOT_W-1:0]         seg_waddr;
  dpfr_pkg::seg_desc_t                 seg_wdata;
  logic [dpfr_pkg::SLOT_W-1:0]         rd_addr;
  logic [DESC_W-1:0]                   seg_rdata;
  dpfr_pkg::seg_desc_t                 cur_desc;

  logic                                bm_we;
  logic [ROW_W-1:0]                    bm_wdata;
  logic [ROW_W-1:0]                    bm_rdata;
  logic [ROW_W-1:0]                    cur_row;

  logic [dpfr_pkg::ADDR_W:0]           diff;
  logic                                match;
  logic                                last;
  dpfr_pkg::result_t                   fwd_res;
  dpfr_pkg::calc_t                     calc;

  // --------------------------------------------------------------------------
  // Configuration registers, saturated on use
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= dpfr_pkg::SHIFT_RST;
      seg_count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpfr_pkg::CFG_PAGE_SHIFT: page_shift_q <= cfg_data_i[dpfr_pkg::SHIFT_W-1:0];
        dpfr_pkg::CFG_SEG_COUNT:  seg_count_q  <= cfg_data_i[dpfr_pkg::SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (page_shift_q < dpfr_pkg::SHIFT_MIN) begin
      shift_eff = dpfr_pkg::SHIFT_MIN;
    end else if (page_shift_q > dpfr_pkg::SHIFT_MAX) begin
      shift_eff = dpfr_pkg::SHIFT_MAX;
    end else begin
      shift_eff = page_shift_q;
    end
    if (32'(seg_count_q) > dpfr_pkg::MAX_SEGMENTS) begin
      cnt_eff = dpfr_pkg::CNT_W'(dpfr_pkg::MAX_SEGMENTS);
    end else begin
      cnt_eff = dpfr_pkg::CNT_W'(seg_count_q);
    end
  end

  // --------------------------------------------------------------------------
  // Input handshake and table writes
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign load_acc    = in_accept && (in_ch.func == dpfr_pkg::FUNC_LOAD);
  assign fault_acc   = in_accept && (in_ch.func == dpfr_pkg::FUNC_FAULT);
  // drop loads into slots beyond the table
  assign slot_ok     = 32'(in_ch.seg_slot) < dpfr_pkg::MAX_SEGMENTS;

  assign seg_we    = load_acc && slot_ok;
  assign seg_waddr = dpfr_pkg::SLOT_W'(in_ch.seg_slot);
  always_comb begin
    seg_wdata.base        = in_ch.seg_base;
    seg_wdata.mem_bytes   = in_ch.seg_mem_size;
    seg_wdata.file_bytes  = in_ch.seg_file_size;
    seg_wdata.file_offset = in_ch.seg_file_offset;
    seg_wdata.perm        = in_ch.seg_perm;
  end

  // Read slot 0 while idle so its data is ready in the first scan cycle;
  // during the scan, read the slot after the one being checked.
  assign rd_addr = (state_q == ST_IDLE) ? '0 : chk_slot_q + dpfr_pkg::SLOT_W'(1);

  dpfr_ram #(
    .WIDTH (DESC_W),
    .DEPTH (dpfr_pkg::MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (rd_addr),
    .rdata_o (seg_rdata)
  );

  // Mapped bits: one row per segment, read alongside its descriptor. A row
  // whose valid flop is clear reads as all unmapped. The row write-back
  // happens in the resolve cycle, before the next transaction can read it.
  assign bm_wdata = row_q | (ROW_W'(1) << calc.page_idx);

  dpfr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (dpfr_pkg::MAX_SEGMENTS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (slot_q),
    .wdata_i (bm_wdata),
    .raddr_i (rd_addr),
    .rdata_o (bm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (seg_we) begin
      row_vld_q[seg_waddr] <= 1'b0;
    end else if (bm_we) begin
      row_vld_q[slot_q] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Segment match for the slot whose descriptor arrives this cycle
  // --------------------------------------------------------------------------
  assign cur_desc = dpfr_pkg::seg_desc_t'(seg_rdata);
  assign cur_row  = row_vld_q[chk_slot_q] ? bm_rdata : '0;
  // A borrow out means the address lies below the base.
  assign diff  = {1'b0, fault_addr_q} - {1'b0, cur_desc.base};
  assign match = !diff[dpfr_pkg::ADDR_W] &&
                 (diff[dpfr_pkg::ADDR_W-1:0] < dpfr_pkg::ADDR_W'(cur_desc.mem_bytes));
  assign last  = dpfr_pkg::CNT_W'(chk_slot_q) == (cnt_eff - dpfr_pkg::CNT_W'(1));

  always_comb begin
    fwd_res        = '0;
    fwd_res.action = dpfr_pkg::ACT_FORWARD;
  end

  dpfr_page_calc u_page_calc (
    .desc_i   (desc_q),
    .offset_i (offset_q),
    .row_i    (row_q),
    .shift_i  (shift_eff),
    .calc_o   (calc)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ch.ready;
  assign out_load = (state_q == ST_EMIT) && out_free;

  always_comb begin
    state_d      = state_q;
    chk_slot_d   = chk_slot_q;
    slot_d       = slot_q;
    fault_addr_d = fault_addr_q;
    desc_d       = desc_q;
    offset_d     = offset_q;
    row_d        = row_q;
    res_d        = res_q;
    bm_we        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (load_acc) begin
          res_d        = '0;
          res_d.action = dpfr_pkg::ACT_LOADED;
          state_d      = ST_EMIT;
        end else if (fault_acc) begin
          fault_addr_d = in_ch.fault_addr;
          chk_slot_d   = '0;
          if (cnt_eff == '0) begin
            res_d   = fwd_res;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          // hold the first matching segment for resolution
          desc_d   = cur_desc;
          offset_d = diff[dpfr_pkg::SIZE_W-1:0];
          row_d    = cur_row;
          slot_d   = chk_slot_q;
          state_d  = ST_RESOLVE;
        end else if (last) begin
          res_d   = fwd_res;
          state_d = ST_EMIT;
        end else begin
          chk_slot_d = chk_slot_q + dpfr_pkg::SLOT_W'(1);
        end
      end
      ST_RESOLVE: begin
        res_d   = calc.res;
        bm_we   = calc.mark;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      chk_slot_q <= '0;
    end else begin
      state_q    <= state_d;
      chk_slot_q <= chk_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    fault_addr_q <= fault_addr_d;
    desc_q       <= desc_d;
    offset_q     <= offset_d;
    row_q        <= row_d;
    res_q        <= res_d;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.action          = out_q.action;
  assign out_ch.page_addr       = out_q.page_addr;
  assign out_ch.map_len         = out_q.map_len;
  assign out_ch.map_file_offset = out_q.map_file_offset;
  assign out_ch.map_perm        = out_q.map_perm;

`ifndef SYNTHESIS
  // A fault with active segments must start the table scan.
  a_fault_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_acc && (cnt_eff != '0)) |=> (state_q == ST_SCAN))
    else $error("fault transaction did not enter the scan");

  // The scan never checks a slot beyond the active count.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (dpfr_pkg::CNT_W'(chk_slot_q) < cnt_eff))
    else $error("scan ran past the active segment count");

  // Only a file or zero-fill result marks a page.
  a_mark_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bm_we |-> ((calc.res.action == dpfr_pkg::ACT_FILE) ||
               (calc.res.action == dpfr_pkg::ACT_ZERO)))
    else $error("mapped bit written for a non-mapping result");

  // Loaded and forwarded results carry no mapping.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && ((out_ch.action == dpfr_pkg::ACT_LOADED) ||
                      (out_ch.action == dpfr_pkg::ACT_FORWARD)))
      |-> ((out_ch.page_addr == '0) && (out_ch.map_len == '0) &&
           (out_ch.map_file_offset == '0) && (out_ch.map_perm == '0)))
    else $error("loaded or forwarded result with nonzero fields");
`endif

endmodule
